### rtl/core/assert_macros.svh
// Assertion macros shared by the thermostat RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Plain property checked at every rising clock edge outside reset.
`define TSQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define TSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TSQ_ASSERT(label, clk, rst_n, prop, msg)
`define TSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/core/tsq_pkg.sv
// Shared types, constants and the duty function of the thermostat block.
package tsq_pkg;

    // Field widths.
    localparam int TEMP_W     = 12;
    localparam int PCT_W      = 7;
    localparam int HYST_W     = 8;
    localparam int MARGIN_W   = 10;
    localparam int STEP_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int DUTY_W     = 13;
    localparam int CALC_W     = TEMP_W + 2;

    // PWM resolution and the duty reciprocal used to divide by one hundred.
    localparam int DUTY_BITS        = 13;
    localparam int DUTY_SHIFT       = 14;
    localparam int DUTY_RECIP_W     = DUTY_BITS + 8;
    localparam int DUTY_PROD_W      = DUTY_RECIP_W + PCT_W;
    localparam logic [63:0] DUTY_FULL  = (64'd1 << DUTY_BITS) - 64'd1;
    localparam logic [63:0] DUTY_RECIP =
        (DUTY_FULL * (64'd1 << DUTY_SHIFT) + 64'd99) / 64'd100;
    localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(90);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_TEMP  = 3'd0,
        REG_AUTO_ENABLE  = 3'd1,
        REG_HEAT_PERCENT = 3'd2,
        REG_HYSTERESIS   = 3'd3,
        REG_LOW_MARGIN   = 3'd4,
        REG_MAX_STEP     = 3'd5,
        REG_MIN_VALID    = 3'd6,
        REG_MAX_VALID    = 3'd7
    } cfg_reg_t;

    // Status LED codes.
    typedef enum logic [1:0] {
        LED_OFF   = 2'd0,
        LED_COLD  = 2'd1,
        LED_READY = 2'd2
    } led_mode_t;

    // Configuration register file contents.
    typedef struct packed {
        logic signed [TEMP_W-1:0] target_temp;
        logic                     auto_enable;
        logic [PCT_W-1:0]         heat_percent;
        logic [HYST_W-1:0]        hysteresis;
        logic [MARGIN_W-1:0]      low_margin;
        logic [STEP_W-1:0]        max_step;
        logic signed [TEMP_W-1:0] min_valid;
        logic signed [TEMP_W-1:0] max_valid;
    } cfg_t;

    // Controller status as seen on the result word.
    typedef struct packed {
        logic              heater_on;
        logic [DUTY_W-1:0] heater_duty;
        led_mode_t         led_mode;
        logic              temp_ok;
    } ctrl_status_t;

    // Duty compare value: full scale times the clamped percent, over one hundred.
    // The rounded-up reciprocal keeps the floor exact for percents up to 90.
    function automatic logic [DUTY_W-1:0] duty_of(input logic [PCT_W-1:0] pct);
        logic [PCT_W-1:0]              pct_c;
        logic [DUTY_PROD_W-1:0]        prod;
        logic [DUTY_PROD_W+DUTY_W-1:0] wide;
        pct_c = (pct > PCT_MAX) ? PCT_MAX : pct;
        prod  = DUTY_PROD_W'(pct_c) * DUTY_PROD_W'(DUTY_RECIP[DUTY_RECIP_W-1:0]);
        wide  = {{DUTY_W{1'b0}}, prod} >> DUTY_SHIFT;
        return wide[DUTY_W-1:0];
    endfunction

endpackage

### rtl/core/tsq_channels.sv
// Sample and result channel interfaces of the thermostat block.
interface tsq_sample_if;
    logic                             valid;
    logic                             ready;
    logic signed [tsq_pkg::TEMP_W-1:0] temp_sample;

    modport source (output valid, output temp_sample, input ready);
    modport sink   (input valid, input temp_sample, output ready);
endinterface

interface tsq_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [tsq_pkg::TEMP_W-1:0] filtered_temp;
    logic                              heater_on;
    logic [tsq_pkg::DUTY_W-1:0]        heater_duty;
    logic [1:0]                        led_mode;
    logic                              temp_ok;

    modport source (output valid, output filtered_temp, output heater_on,
                    output heater_duty, output led_mode, output temp_ok, input ready);
    modport sink   (input valid, input filtered_temp, input heater_on,
                    input heater_duty, input led_mode, input temp_ok, output ready);
endinterface

### rtl/core/tsq_cfg_regs.sv
// Configuration register file of the thermostat block.
module tsq_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [tsq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output tsq_pkg::cfg_t                    cfg
);

    tsq_pkg::cfg_t cfg_reg;
    tsq_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (tsq_pkg::cfg_reg_t'(cfg_index))
                tsq_pkg::REG_TARGET_TEMP:
                    cfg_next.target_temp  = $signed(cfg_wdata[tsq_pkg::TEMP_W-1:0]);
                tsq_pkg::REG_AUTO_ENABLE:
                    cfg_next.auto_enable  = cfg_wdata[0];
                tsq_pkg::REG_HEAT_PERCENT:
                    cfg_next.heat_percent = cfg_wdata[tsq_pkg::PCT_W-1:0];
                tsq_pkg::REG_HYSTERESIS:
                    cfg_next.hysteresis   = cfg_wdata[tsq_pkg::HYST_W-1:0];
                tsq_pkg::REG_LOW_MARGIN:
                    cfg_next.low_margin   = cfg_wdata[tsq_pkg::MARGIN_W-1:0];
                tsq_pkg::REG_MAX_STEP:
                    cfg_next.max_step     = cfg_wdata[tsq_pkg::STEP_W-1:0];
                tsq_pkg::REG_MIN_VALID:
                    cfg_next.min_valid    = $signed(cfg_wdata[tsq_pkg::TEMP_W-1:0]);
                tsq_pkg::REG_MAX_VALID:
                    cfg_next.max_valid    = $signed(cfg_wdata[tsq_pkg::TEMP_W-1:0]);
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Register file with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_temp  <= 12'sd320;
            cfg_reg.auto_enable  <= 1'b0;
            cfg_reg.heat_percent <= 7'd90;
            cfg_reg.hysteresis   <= 8'd5;
            cfg_reg.low_margin   <= 10'd48;
            cfg_reg.max_step     <= 11'd32;
            cfg_reg.min_valid    <= -12'sd160;
            cfg_reg.max_valid    <= 12'sd960;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/tsq_qualifier.sv
// Sample qualifier: window and step checks that produce the filtered temperature.
`include "assert_macros.svh"

module tsq_qualifier (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  logic signed [tsq_pkg::TEMP_W-1:0] sample,
    input  tsq_pkg::cfg_t                     cfg,
    output logic signed [tsq_pkg::TEMP_W-1:0] qual_next,
    output logic signed [tsq_pkg::TEMP_W-1:0] filtered_temp
);

    logic signed [tsq_pkg::TEMP_W-1:0] last_sample_reg;
    logic signed [tsq_pkg::TEMP_W-1:0] qual_reg;
    logic signed [tsq_pkg::TEMP_W:0]   diff;
    logic [tsq_pkg::TEMP_W:0]          diff_mag;
    logic                              in_window;
    logic                              step_ok;

    // Window test and step size against the previous raw sample.
    always_comb
    begin
        in_window = (sample > cfg.min_valid) && (sample < cfg.max_valid);
        diff      = $signed({sample[tsq_pkg::TEMP_W-1], sample})
                  - $signed({last_sample_reg[tsq_pkg::TEMP_W-1], last_sample_reg});
        diff_mag  = diff[tsq_pkg::TEMP_W] ? $unsigned(-diff) : $unsigned(diff);
        step_ok   = diff_mag < {{(tsq_pkg::TEMP_W + 1 - tsq_pkg::STEP_W){1'b0}},
                                cfg.max_step};
        if (!in_window)
            qual_next = last_sample_reg;
        else if (step_ok)
            qual_next = sample;
        else
            qual_next = qual_reg;
    end

    // Qualifier state, updated once per processed word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg <= '0;
            qual_reg        <= '0;
        end
        else if (fire)
        begin
            last_sample_reg <= sample;
            qual_reg        <= qual_next;
        end
    end

    assign filtered_temp = qual_reg;

    // An out-of-window sample falls back to the previous raw sample.
    `TSQ_ASSERT_NEXT(a_window_fallback, clk, rst_n, fire && !in_window, qual_reg == $past(last_sample_reg), "out-of-window sample did not take previous raw sample")

endmodule

### rtl/core/tsq_control.sv
// Heater and LED controller with hysteresis, plus the PWM duty value.
`include "assert_macros.svh"

module tsq_control (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  logic signed [tsq_pkg::TEMP_W-1:0] qual_next,
    input  tsq_pkg::cfg_t                     cfg,
    output tsq_pkg::ctrl_status_t             status
);

    logic                        heater_reg;
    logic                        heater_next;
    tsq_pkg::led_mode_t          led_reg;
    tsq_pkg::led_mode_t          led_next;
    logic                        ready_reg;
    logic                        ready_next;
    logic                        was_enabled_reg;
    logic                        was_enabled_next;
    logic [tsq_pkg::DUTY_W-1:0]  duty_reg;

    logic signed [tsq_pkg::CALC_W-1:0] temp_w;
    logic signed [tsq_pkg::CALC_W-1:0] target_w;
    logic signed [tsq_pkg::CALC_W-1:0] band_lo;
    logic signed [tsq_pkg::CALC_W-1:0] band_hi;
    logic signed [tsq_pkg::CALC_W-1:0] cold_lvl;

    // Thresholds around the setpoint, widened so no sum wraps.
    always_comb
    begin
        temp_w   = tsq_pkg::CALC_W'(qual_next);
        target_w = tsq_pkg::CALC_W'(cfg.target_temp);
        band_lo  = target_w - $signed({{(tsq_pkg::CALC_W - tsq_pkg::HYST_W){1'b0}},
                                       cfg.hysteresis});
        band_hi  = target_w + $signed({{(tsq_pkg::CALC_W - tsq_pkg::HYST_W){1'b0}},
                                       cfg.hysteresis});
        cold_lvl = target_w - $signed({{(tsq_pkg::CALC_W - tsq_pkg::MARGIN_W){1'b0}},
                                       cfg.low_margin});
    end

    // Next controller state; disabling forces heater and LED off once.
    always_comb
    begin
        heater_next      = heater_reg;
        led_next         = led_reg;
        ready_next       = ready_reg;
        was_enabled_next = was_enabled_reg;
        if (!cfg.auto_enable)
        begin
            if (was_enabled_reg)
            begin
                was_enabled_next = 1'b0;
                heater_next      = 1'b0;
                led_next         = tsq_pkg::LED_OFF;
            end
        end
        else
        begin
            was_enabled_next = 1'b1;
            if (temp_w < band_lo)
                heater_next = 1'b1;
            else if (temp_w > band_hi)
                heater_next = 1'b0;

            if (temp_w < cold_lvl)
            begin
                led_next   = tsq_pkg::LED_COLD;
                ready_next = 1'b0;
            end
            else if (temp_w > band_lo)
            begin
                led_next   = tsq_pkg::LED_READY;
                ready_next = 1'b1;
            end
        end
    end

    // Controller state and the duty value for this word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heater_reg      <= 1'b0;
            led_reg         <= tsq_pkg::LED_OFF;
            ready_reg       <= 1'b0;
            was_enabled_reg <= 1'b1;
            duty_reg        <= '0;
        end
        else if (fire)
        begin
            heater_reg      <= heater_next;
            led_reg         <= led_next;
            ready_reg       <= ready_next;
            was_enabled_reg <= was_enabled_next;
            duty_reg        <= tsq_pkg::duty_of(cfg.heat_percent);
        end
    end

    // Duty reads zero while the heater is off.
    always_comb
    begin
        status.heater_on   = heater_reg;
        status.heater_duty = heater_reg ? duty_reg : '0;
        status.led_mode    = led_reg;
        status.temp_ok     = ready_reg;
    end

    // A disabled word leaves heater and LED off.
    `TSQ_ASSERT_NEXT(a_disable_forces_off, clk, rst_n, fire && !cfg.auto_enable, !heater_reg && (led_reg == tsq_pkg::LED_OFF), "disabled control left heater or LED on")
    // LED and ready flag agree while the LED shows cold or ready.
    `TSQ_ASSERT_IMPL(a_cold_not_ok, clk, rst_n, led_reg == tsq_pkg::LED_COLD, !ready_reg, "cold LED with ok flag set")
    `TSQ_ASSERT_IMPL(a_ready_is_ok, clk, rst_n, led_reg == tsq_pkg::LED_READY, ready_reg, "ready LED with ok flag clear")

endmodule

### rtl/core/thermostat_with_sample_qualifier.sv
// Top level of the thermostat with sample qualifier.
//
//   channel   direction  word contents
//   sample    in         temp_sample
//   result    out        filtered_temp, heater_on, heater_duty, led_mode, temp_ok
//   cfg       in         cfg_wr_en, cfg_index, cfg_wdata (write only)
//
// One word per cycle sustained while the result side takes each word. A word accepted
// into the sample register passes the qualifier and controller and, once the result
// slot is free, updates the registered result state, which the result channel offers.
// Reset is asynchronous and active low and leaves the block ready at once.
// A stalled result holds the state; the sample register still takes one word.
`include "assert_macros.svh"

module thermostat_with_sample_qualifier (
    input  logic                           clk,
    input  logic                           rst_n,
    tsq_sample_if.sink                     sample,
    tsq_result_if.source                   result,
    input  logic                           cfg_wr_en,
    input  logic [tsq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    tsq_pkg::cfg_t                     cfg;
    tsq_pkg::ctrl_status_t             status;
    logic                              s1_valid_reg;
    logic signed [tsq_pkg::TEMP_W-1:0] s1_sample_reg;
    logic                              out_valid_reg;
    logic                              advance;
    logic                              fire;
    logic signed [tsq_pkg::TEMP_W-1:0] qual_next;
    logic signed [tsq_pkg::TEMP_W-1:0] filtered_temp;

    tsq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Handshake: the result slot frees when empty or taken.
    assign advance      = !out_valid_reg || result.ready;
    assign fire         = s1_valid_reg && advance;
    assign sample.ready = !s1_valid_reg || advance;

    // Input register and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.valid && sample.ready)
                s1_valid_reg <= 1'b1;
            else if (fire)
                s1_valid_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Sample payload register.
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
            s1_sample_reg <= sample.temp_sample;
    end

    tsq_qualifier u_qual (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .sample        (s1_sample_reg),
        .cfg           (cfg),
        .qual_next     (qual_next),
        .filtered_temp (filtered_temp)
    );

    tsq_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .qual_next (qual_next),
        .cfg       (cfg),
        .status    (status)
    );

    // Result word comes straight from the updated state.
    assign result.valid         = out_valid_reg;
    assign result.filtered_temp = filtered_temp;
    assign result.heater_on     = status.heater_on;
    assign result.heater_duty   = status.heater_duty;
    assign result.led_mode      = status.led_mode;
    assign result.temp_ok       = status.temp_ok;

    // A processed word always shows up as a result.
    `TSQ_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, out_valid_reg, "processed word gave no result")
    // A held sample stays put while the result side stalls.
    `TSQ_ASSERT_NEXT(a_sample_held, clk, rst_n, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_sample_reg), "held sample changed during stall")

endmodule
